[rtl/csl_pkg.sv]
// Shared types, codes and constants of the charge status LED controller.
`default_nettype none

package csl_pkg;

	// Field widths
	localparam int CAP_W      = 16;
	localparam int PERMILLE_W = 10;
	localparam int LEVEL_W    = 8;
	localparam int CHIP_W     = 2;
	localparam int CHARGE_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int TICK_W     = 4;
	localparam int TICK_N     = 2 ** TICK_W;
	localparam int LEDS_W     = 4;

	// Quotient of 1000 * remaining / full needs the full product width.
	localparam int Q_W    = CAP_W + PERMILLE_W;
	localparam int STEP_W = $clog2(Q_W);

	localparam logic [PERMILLE_W-1:0] PERMILLE_SCALE = PERMILLE_W'(1000);

	// Configuration reset values
	localparam logic [PERMILLE_W-1:0] CRITICAL_RST = PERMILLE_W'(71);
	localparam logic [PERMILLE_W-1:0] LOW_RST      = PERMILLE_W'(137);
	localparam logic [PERMILLE_W-1:0] FULL_RST     = PERMILLE_W'(937);

	// Blink timing defaults, in ticks
	localparam int SLOW_PERIOD_DEF = 16;
	localparam int FAST_PERIOD_DEF = 8;
	localparam int SHORT_ON_DEF    = 4;
	localparam int LONG_ON_DEF     = 8;

	typedef enum logic {
		OP_TICK   = 1'b0,
		OP_MANUAL = 1'b1
	} op_t;

	typedef enum logic [CHIP_W-1:0] {
		CHIP_OFF     = 2'd0,
		CHIP_SUSPEND = 2'd1,
		CHIP_ON      = 2'd2,
		CHIP_TRANS   = 2'd3
	} chip_t;

	typedef enum logic [CHARGE_W-1:0] {
		CHG_CHARGE    = 3'd0,
		CHG_NEAR_FULL = 3'd1,
		CHG_DISCHARGE = 3'd2,
		CHG_ERROR     = 3'd3,
		CHG_IDLE      = 3'd4,
		CHG_OTHER     = 3'd5
	} charge_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CRITICAL = 2'd0,
		CFG_LOW      = 2'd1,
		CFG_FULL     = 2'd2
	} cfg_idx_t;

	// Two-bit LED color: bit 0 blue pin, bit 1 amber pin
	localparam logic [1:0] COLOR_OFF   = 2'b00;
	localparam logic [1:0] COLOR_BLUE  = 2'b01;
	localparam logic [1:0] COLOR_AMBER = 2'b10;

	// Item fields the LED update needs (capacities go straight to the divider)
	typedef struct packed {
		logic                op;
		logic                led_select;
		logic [LEVEL_W-1:0]  blue_level;
		logic [LEVEL_W-1:0]  yellow_level;
		logic                power_auto;
		logic                battery_auto;
		logic [CHIP_W-1:0]   chipset_state;
		logic [CHARGE_W-1:0] chg_state;
		logic                force_idle;
	} csl_item_t;

	typedef struct packed {
		logic [PERMILLE_W-1:0] critical_permille;
		logic [PERMILLE_W-1:0] low_permille;
		logic [PERMILLE_W-1:0] full_permille;
	} csl_cfg_t;

	// Per-count blink pattern: bit i set when (i mod period) < on_ticks.
	function automatic logic [TICK_N-1:0] phase_mask(int period, int on_ticks);
		int                ph;
		logic [TICK_N-1:0] m;
		begin
			ph = 0;
			m  = '0;
			for (int i = 0; i < TICK_N; i++) begin
				m[i] = (ph < on_ticks);
				ph   = (ph == period - 1) ? 0 : ph + 1;
			end
			return m;
		end
	endfunction

endpackage

`default_nettype wire

[rtl/csl_if.sv]
// Handshake channel interfaces: item input, LED result output, config write.
`default_nettype none

interface csl_item_if;
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic                         led_select;
	logic [csl_pkg::LEVEL_W-1:0]  blue_level;
	logic [csl_pkg::LEVEL_W-1:0]  yellow_level;
	logic                         power_auto;
	logic                         battery_auto;
	logic [csl_pkg::CHIP_W-1:0]   chipset_state;
	logic [csl_pkg::CHARGE_W-1:0] chg_state;
	logic                         force_idle;
	logic [csl_pkg::CAP_W-1:0]    remain_cap;
	logic [csl_pkg::CAP_W-1:0]    full_capacity;

	modport source (
		output valid, op, led_select, blue_level, yellow_level, power_auto,
		       battery_auto, chipset_state, chg_state, force_idle,
		       remain_cap, full_capacity,
		input  ready
	);
	modport sink (
		input  valid, op, led_select, blue_level, yellow_level, power_auto,
		       battery_auto, chipset_state, chg_state, force_idle,
		       remain_cap, full_capacity,
		output ready
	);
endinterface

interface csl_result_if;
	logic valid;
	logic ready;
	logic power_blue;
	logic power_amber;
	logic battery_blue;
	logic battery_amber;

	modport source (
		output valid, power_blue, power_amber, battery_blue, battery_amber,
		input  ready
	);
	modport sink (
		input  valid, power_blue, power_amber, battery_blue, battery_amber,
		output ready
	);
endinterface

interface csl_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [csl_pkg::CFG_IDX_W-1:0]  index;
	logic [csl_pkg::PERMILLE_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/csl_permille_div.sv]
// Bit-serial restoring divider for permille = 1000 * remaining / full.
`default_nettype none

module csl_permille_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [csl_pkg::CAP_W-1:0]   remaining,
	input  wire logic [csl_pkg::CAP_W-1:0]   full,
	output logic                             busy,
	output logic                             done,
	output logic [csl_pkg::Q_W-1:0]          permille
);
	import csl_pkg::*;

	logic [Q_W-1:0]    num_q;   // dividend shifts out, quotient shifts in
	logic [CAP_W-1:0]  rem_q;
	logic [CAP_W-1:0]  div_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              zero_q;

	logic [Q_W-1:0]    prod;
	logic [CAP_W:0]    trial;
	logic              ge;
	logic [CAP_W-1:0]  rem_d;

	assign prod  = Q_W'(remaining) * Q_W'(PERMILLE_SCALE);
	assign trial = {rem_q, num_q[Q_W-1]};
	assign ge    = (trial >= {1'b0, div_q});
	assign rem_d = ge ? CAP_W'(trial - {1'b0, div_q}) : trial[CAP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= prod;
			rem_q  <= '0;
			div_q  <= full;
			zero_q <= (full == '0);
		end else if (busy_q) begin
			num_q <= {num_q[Q_W-2:0], ge};
			rem_q <= rem_d;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign permille = zero_q ? '0 : num_q;

`ifndef ASSERT_OFF
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(busy_q) && !busy_q)) else $error("done without a run");
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (busy_q && cnt_q == '0)) else $error("start did not begin a run");
`endif

endmodule

`default_nettype wire

[rtl/csl_led_update.sv]
// LED state: blink counters, suspend flag, pin levels and their update rules.
`default_nettype none

module csl_led_update #(
	parameter int SLOW_PERIOD = csl_pkg::SLOW_PERIOD_DEF,
	parameter int FAST_PERIOD = csl_pkg::FAST_PERIOD_DEF,
	parameter int SHORT_ON    = csl_pkg::SHORT_ON_DEF,
	parameter int LONG_ON     = csl_pkg::LONG_ON_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        apply,
	input  wire csl_pkg::csl_item_t          item_in,
	input  wire csl_pkg::csl_cfg_t           cfg_in,
	input  wire logic [csl_pkg::Q_W-1:0]     permille,
	output logic [csl_pkg::LEDS_W-1:0]       levels
);
	import csl_pkg::*;

	localparam logic [TICK_N-1:0] SLOW_SHORT = phase_mask(SLOW_PERIOD, SHORT_ON);
	localparam logic [TICK_N-1:0] FAST_SHORT = phase_mask(FAST_PERIOD, SHORT_ON);
	localparam logic [TICK_N-1:0] SLOW_LONG  = phase_mask(SLOW_PERIOD, LONG_ON);

	logic [TICK_W-1:0] p_cnt_q, p_cnt_d;
	logic [TICK_W-1:0] b_cnt_q, b_cnt_d;
	logic              was_susp_q, was_susp_d;
	logic [LEDS_W-1:0] lv_q, lv_d;

	logic [TICK_W-1:0] p_inc, b_inc;
	logic [1:0]        man_color;
	logic              below_full, at_critical, at_low;

	assign p_inc       = p_cnt_q + TICK_W'(1);
	assign b_inc       = b_cnt_q + TICK_W'(1);
	assign man_color   = {item_in.yellow_level != '0, item_in.blue_level != '0};
	assign below_full  = (permille <  Q_W'(cfg_in.full_permille));
	assign at_critical = (permille <= Q_W'(cfg_in.critical_permille));
	assign at_low      = (permille <= Q_W'(cfg_in.low_permille));

	always_comb begin
		p_cnt_d    = p_cnt_q;
		b_cnt_d    = b_cnt_q;
		was_susp_d = was_susp_q;
		lv_d       = lv_q;
		if (item_in.op == OP_MANUAL) begin
			if (item_in.led_select) begin
				lv_d[3:2] = man_color;
			end else begin
				lv_d[1:0] = man_color;
			end
		end else begin
			if (item_in.power_auto) begin
				p_cnt_d    = p_inc;
				was_susp_d = 1'b0;
				case (item_in.chipset_state)
					CHIP_SUSPEND: begin
						// blink phase restarts on suspend entry
						p_cnt_d    = was_susp_q ? p_inc : '0;
						lv_d[1:0]  = SLOW_SHORT[p_cnt_d] ? COLOR_AMBER : COLOR_OFF;
						was_susp_d = 1'b1;
					end
					CHIP_OFF: lv_d[1:0] = COLOR_OFF;
					CHIP_ON:  lv_d[1:0] = COLOR_BLUE;
					default:  ;
				endcase
			end
			if (item_in.battery_auto) begin
				b_cnt_d = b_inc;
				case (item_in.chg_state)
					CHG_CHARGE:    lv_d[3:2] = below_full ? COLOR_AMBER : COLOR_BLUE;
					CHG_NEAR_FULL: lv_d[3:2] = COLOR_BLUE;
					CHG_DISCHARGE: begin
						if (item_in.chipset_state != CHIP_OFF && at_critical) begin
							lv_d[3:2] = FAST_SHORT[b_inc] ? COLOR_AMBER : COLOR_OFF;
						end else if (item_in.chipset_state != CHIP_OFF && at_low) begin
							lv_d[3:2] = SLOW_SHORT[b_inc] ? COLOR_AMBER : COLOR_OFF;
						end else begin
							lv_d[3:2] = COLOR_OFF;
						end
					end
					CHG_ERROR: lv_d[3:2] = FAST_SHORT[b_inc] ? COLOR_AMBER : COLOR_OFF;
					CHG_IDLE: begin
						if (item_in.force_idle) begin
							lv_d[3:2] = SLOW_LONG[b_inc] ? COLOR_BLUE : COLOR_AMBER;
						end else begin
							lv_d[3:2] = COLOR_BLUE;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_cnt_q    <= '0;
			b_cnt_q    <= '0;
			was_susp_q <= 1'b0;
			lv_q       <= '0;
		end else if (apply) begin
			p_cnt_q    <= p_cnt_d;
			b_cnt_q    <= b_cnt_d;
			was_susp_q <= was_susp_d;
			lv_q       <= lv_d;
		end
	end

	assign levels = lv_q;

`ifndef ASSERT_OFF
	a_manual_keeps_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(apply && item_in.op == OP_MANUAL) |=> ($stable(p_cnt_q) && $stable(b_cnt_q)))
		else $error("manual set moved a blink counter");
	a_suspend_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(apply && item_in.op == OP_TICK && item_in.power_auto &&
		 item_in.chipset_state == CHIP_SUSPEND && !was_susp_q) |=> (p_cnt_q == '0))
		else $error("suspend entry did not restart power blink");
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!apply |=> $stable(lv_q)) else $error("LED levels changed without an update");
`endif

endmodule

`default_nettype wire

[rtl/charge_status_led_controller.sv]
// Top level of the charge status LED controller: channels, config, sequencing.
`default_nettype none

// Drives a power LED and a battery LED, each with a blue and an amber pin.
// Every input beat yields exactly one result beat carrying all four pin levels
// after that beat. A tick beat (op 0) stands for 250 ms: with power_auto the
// power LED follows chipset_state (suspend blinks amber, restarting its phase
// on suspend entry), and with battery_auto the battery LED follows
// chg_state and the charge level in permille. A manual beat (op 1) sets one
// LED from blue_level and yellow_level. Thresholds are written through the cfg
// channel (index 0 critical, 1 low, 2 full; other indexes are ignored); the
// user must write them only while the block is idle, which the block itself
// does not enforce. A tick with battery_auto set first runs the bit-serial
// divider, which retires one quotient bit per cycle over 26 bits, then hands
// over to the apply step, which commits once the result slot is free; every
// other beat goes straight to the apply step. One beat is worked on at a time;
// the next beat is accepted while a finished result still waits to be taken.
module charge_status_led_controller #(
	parameter int SLOW_PERIOD = csl_pkg::SLOW_PERIOD_DEF,
	parameter int FAST_PERIOD = csl_pkg::FAST_PERIOD_DEF,
	parameter int SHORT_ON    = csl_pkg::SHORT_ON_DEF,
	parameter int LONG_ON     = csl_pkg::LONG_ON_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	csl_item_if.sink    item,
	csl_result_if.source result,
	csl_cfg_if.sink     cfg
);
	import csl_pkg::*;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_DIV   = 3'b010,
		ST_APPLY = 3'b100
	} state_t;

	state_t            state_q;
	csl_item_t         item_q;
	csl_cfg_t          cfg_q;
	logic              res_valid_q;

	logic              accept;
	logic              div_start;
	logic              div_busy;
	logic              div_done;
	logic [Q_W-1:0]    permille;
	logic              apply;
	logic [LEDS_W-1:0] levels;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	// only a battery tick needs the charge level
	assign div_start  = accept && (item.op == OP_TICK) && item.battery_auto;
	// commit once the result slot is free or being emptied this cycle
	assign apply      = (state_q == ST_APPLY) && (!res_valid_q || result.ready);

	// config registers; writes land at once
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.critical_permille <= CRITICAL_RST;
			cfg_q.low_permille      <= LOW_RST;
			cfg_q.full_permille     <= FULL_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_CRITICAL: cfg_q.critical_permille <= cfg.data;
				CFG_LOW:      cfg_q.low_permille      <= cfg.data;
				CFG_FULL:     cfg_q.full_permille     <= cfg.data;
				default:      ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (apply) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end else if (accept) begin
						state_q <= ST_APPLY;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (apply) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// captured beat payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.op            <= item.op;
			item_q.led_select    <= item.led_select;
			item_q.blue_level    <= item.blue_level;
			item_q.yellow_level  <= item.yellow_level;
			item_q.power_auto    <= item.power_auto;
			item_q.battery_auto  <= item.battery_auto;
			item_q.chipset_state <= item.chipset_state;
			item_q.chg_state     <= item.chg_state;
			item_q.force_idle    <= item.force_idle;
		end
	end

	csl_permille_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.remaining (item.remain_cap),
		.full      (item.full_capacity),
		.busy      (div_busy),
		.done      (div_done),
		.permille  (permille)
	);

	csl_led_update #(
		.SLOW_PERIOD (SLOW_PERIOD),
		.FAST_PERIOD (FAST_PERIOD),
		.SHORT_ON    (SHORT_ON),
		.LONG_ON     (LONG_ON)
	) u_led (
		.clk      (clk),
		.arst_n   (arst_n),
		.apply    (apply),
		.item_in  (item_q),
		.cfg_in   (cfg_q),
		.permille (permille),
		.levels   (levels)
	);

	// LED state only moves on apply, which waits for the slot, so the state
	// itself is the result payload
	assign result.valid         = res_valid_q;
	assign result.power_blue    = levels[0];
	assign result.power_amber   = levels[1];
	assign result.battery_blue  = levels[2];
	assign result.battery_amber = levels[3];

`ifndef ASSERT_OFF
	a_div_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_busy || div_done))
		else $error("waiting on divider that is not running");
	a_start_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == ST_DIV)) else $error("divide start missed");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |=> $stable(levels))
		else $error("pending result changed");
`endif

endmodule

`default_nettype wire

[test/charge_status_led_controller_test.sv]
// Self-checking testbench for the charge status LED controller.
`timescale 1ns / 100ps

module charge_status_led_controller_test;
	import csl_pkg::*;

	// Blink timing of the block as instantiated (package defaults)
	localparam int SLOW_TICKS  = SLOW_PERIOD_DEF;
	localparam int FAST_TICKS  = FAST_PERIOD_DEF;
	localparam int SHORT_TICKS = SHORT_ON_DEF;
	localparam int LONG_TICKS  = LONG_ON_DEF;

	// Config index with no register behind it; the block must ignore it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam int MAX_REPORTS    = 10;
	localparam int HOLD_CYCLES    = 150;   // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on any channel
	localparam int SETTLE_CYCLES  = 40;    // longer than the divide path

	// One input beat with typed fields
	typedef struct {
		op_t                 op;
		logic                led_select;
		logic [LEVEL_W-1:0]  blue_level;
		logic [LEVEL_W-1:0]  yellow_level;
		logic                power_auto;
		logic                battery_auto;
		chip_t               chipset_state;
		charge_t             chg_state;
		logic                force_idle;
		logic [CAP_W-1:0]    remain_cap;
		logic [CAP_W-1:0]    full_capacity;
	} led_beat_t;

	logic clk;
	logic arst_n;

	csl_item_if   item_bus();
	csl_result_if result_bus();
	csl_cfg_if    cfg_bus();

	charge_status_led_controller i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	// ------------------------------------------------------------------
	// Predictor state: thresholds, blink counters, pin levels.
	// leds: bit 0 power blue, 1 power amber, 2 battery blue, 3 battery amber
	// ------------------------------------------------------------------
	logic [PERMILLE_W-1:0] crit_pm;
	logic [PERMILLE_W-1:0] low_pm;
	logic [PERMILLE_W-1:0] full_pm;
	logic [TICK_W-1:0]     pwr_ticks;
	logic                  in_suspend;
	logic [TICK_W-1:0]     batt_ticks;
	logic [LEDS_W-1:0]     leds;

	logic [LEDS_W-1:0] expected_leds[$];

	int mismatches   = 0;
	int results_seen = 0;
	int ticks_sent   = 0;
	int manuals_sent = 0;
	int reg_writes   = 0;
	int stall_cycles = 0;

	// Idle mix; receiver reads its percentage in its own process
	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int hold_seq      = 0;
	int hold_seen     = 0;

	// Random traffic runs: chipset, charge state and forced idle persist
	// across ticks so suspend phases and blink patterns actually develop.
	chip_t   run_chip   = CHIP_ON;
	charge_t run_charge = CHG_DISCHARGE;
	logic    run_forced = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic bit in_on_phase(logic [TICK_W-1:0] cnt, int period, int on_len);
		return (int'(cnt) % period) < on_len;
	endfunction

	function automatic logic [LEDS_W-1:0] predict_leds(led_beat_t b);
		logic [31:0] level;
		logic [1:0]  color;
		if (b.op == OP_MANUAL) begin
			color = {b.yellow_level != '0, b.blue_level != '0};
			if (b.led_select)
				leds[3:2] = color;
			else
				leds[1:0] = color;
			return leds;
		end
		if (b.power_auto) begin
			pwr_ticks = pwr_ticks + 1'b1;
			if (b.chipset_state == CHIP_SUSPEND) begin
				// entering suspend restarts the blink phase
				if (!in_suspend)
					pwr_ticks = '0;
				leds[1:0] = in_on_phase(pwr_ticks, SLOW_TICKS, SHORT_TICKS) ?
				            COLOR_AMBER : COLOR_OFF;
				in_suspend = 1'b1;
			end else begin
				in_suspend = 1'b0;
				if (b.chipset_state == CHIP_OFF)
					leds[1:0] = COLOR_OFF;
				else if (b.chipset_state == CHIP_ON)
					leds[1:0] = COLOR_BLUE;
				// transitional: pins hold
			end
		end
		if (b.battery_auto) begin
			batt_ticks = batt_ticks + 1'b1;
			// may exceed 1000 when remaining is above full
			level = (b.full_capacity == '0) ? 32'd0 :
			        (32'd1000 * b.remain_cap) / b.full_capacity;
			case (b.chg_state)
				CHG_CHARGE: begin
					leds[3:2] = (level < full_pm) ? COLOR_AMBER : COLOR_BLUE;
				end
				CHG_NEAR_FULL: begin
					leds[3:2] = COLOR_BLUE;
				end
				CHG_DISCHARGE: begin
					if (b.chipset_state != CHIP_OFF && level <= crit_pm)
						leds[3:2] = in_on_phase(batt_ticks, FAST_TICKS, SHORT_TICKS) ?
						            COLOR_AMBER : COLOR_OFF;
					else if (b.chipset_state != CHIP_OFF && level <= low_pm)
						leds[3:2] = in_on_phase(batt_ticks, SLOW_TICKS, SHORT_TICKS) ?
						            COLOR_AMBER : COLOR_OFF;
					else
						leds[3:2] = COLOR_OFF;
				end
				CHG_ERROR: begin
					leds[3:2] = in_on_phase(batt_ticks, FAST_TICKS, SHORT_TICKS) ?
					            COLOR_AMBER : COLOR_OFF;
				end
				CHG_IDLE: begin
					if (b.force_idle)
						leds[3:2] = in_on_phase(batt_ticks, SLOW_TICKS, LONG_TICKS) ?
						            COLOR_BLUE : COLOR_AMBER;
					else
						leds[3:2] = COLOR_BLUE;
				end
				default: begin
					// other states: counter moved, pins hold
				end
			endcase
		end
		return leds;
	endfunction

	// ------------------------------------------------------------------
	// Beat builders
	// ------------------------------------------------------------------
	function automatic led_beat_t make_tick(logic pa, logic ba, chip_t chip, charge_t chg,
	                                        logic forced, int rem, int full_cap);
		led_beat_t b;
		b.op                 = OP_TICK;
		b.led_select         = 1'($urandom_range(1));     // ignored on a tick
		b.blue_level         = LEVEL_W'($urandom);
		b.yellow_level       = LEVEL_W'($urandom);
		b.power_auto         = pa;
		b.battery_auto       = ba;
		b.chipset_state      = chip;
		b.chg_state          = chg;
		b.force_idle         = forced;
		b.remain_cap         = CAP_W'(rem);
		b.full_capacity      = CAP_W'(full_cap);
		return b;
	endfunction

	function automatic led_beat_t make_manual(logic sel, int blue, int yellow);
		led_beat_t b;
		// tick fields carry junk; a manual set must not look at them
		b = make_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
		              chip_t'($urandom_range(3)), charge_t'($urandom_range(5)),
		              1'($urandom_range(1)), $urandom, $urandom);
		b.op           = OP_MANUAL;
		b.led_select   = sel;
		b.blue_level   = LEVEL_W'(blue);
		b.yellow_level = LEVEL_W'(yellow);
		return b;
	endfunction

	function automatic led_beat_t random_beat();
		led_beat_t b;
		int        pick;
		int        target;
		int        full_cap;
		int        rem;
		if ($urandom_range(99) < 18) begin
			return make_manual(1'($urandom_range(1)),
			                   ($urandom_range(3) == 0) ? 0 : $urandom_range(255),
			                   ($urandom_range(3) == 0) ? 0 : $urandom_range(255));
		end
		if ($urandom_range(99) < 12)
			run_chip = chip_t'($urandom_range(3));
		if ($urandom_range(99) < 10)
			run_charge = charge_t'($urandom_range(5));
		if ($urandom_range(99) < 10)
			run_forced = ~run_forced;

		// Capacities: mostly aimed at a threshold so the compares flip
		pick = $urandom_range(9);
		if (pick == 0) begin
			full_cap = 0;
			rem      = $urandom_range(65535);
		end else if (pick == 1) begin
			full_cap = $urandom_range(65535);
			rem      = $urandom_range(65535);
		end else begin
			full_cap = (pick < 4) ? $urandom_range(65535, 1) : $urandom_range(2000, 1);
			case ($urandom_range(3))
				0:       target = int'(crit_pm);
				1:       target = int'(low_pm);
				2:       target = int'(full_pm);
				default: target = $urandom_range(1050);
			endcase
			target = target + int'($urandom_range(2)) - 1;
			if (target < 0)
				target = 0;
			rem = (target * full_cap + 999) / 1000;
			if (rem > 65535)
				rem = 65535;
		end
		b = make_tick(($urandom_range(9) != 0), ($urandom_range(9) != 0),
		              run_chip, run_charge, run_forced, rem, full_cap);
		return b;
	endfunction

	// ------------------------------------------------------------------
	// Sender: optional idle gaps, then hold valid until the beat is taken.
	// valid stays high into the next beat unless a gap is rolled.
	// ------------------------------------------------------------------
	task automatic send_beat(led_beat_t b);
		while ($urandom_range(99) < src_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid              <= 1'b1;
		item_bus.op                 <= b.op;
		item_bus.led_select         <= b.led_select;
		item_bus.blue_level         <= b.blue_level;
		item_bus.yellow_level       <= b.yellow_level;
		item_bus.power_auto         <= b.power_auto;
		item_bus.battery_auto       <= b.battery_auto;
		item_bus.chipset_state      <= b.chipset_state;
		item_bus.chg_state          <= b.chg_state;
		item_bus.force_idle         <= b.force_idle;
		item_bus.remain_cap         <= b.remain_cap;
		item_bus.full_capacity      <= b.full_capacity;
		do @(posedge clk); while (!item_bus.ready);
		expected_leds.push_back(predict_leds(b));
		if (b.op == OP_TICK)
			ticks_sent++;
		else
			manuals_sent++;
	endtask

	// Stop offering and wait for every outstanding result
	task automatic drain();
		item_bus.valid <= 1'b0;
		while (expected_leds.size() != 0)
			@(posedge clk);
	endtask

	// Writes all three thresholds plus the unused index, block idle
	task automatic apply_thresholds(int crit, int low, int full_lvl);
		logic [CFG_IDX_W-1:0]  idx   [4];
		logic [PERMILLE_W-1:0] value [4];
		drain();
		idx[0] = CFG_CRITICAL; value[0] = PERMILLE_W'(crit);
		idx[1] = CFG_LOW;      value[1] = PERMILLE_W'(low);
		idx[2] = CFG_FULL;     value[2] = PERMILLE_W'(full_lvl);
		idx[3] = CFG_UNUSED;   value[3] = PERMILLE_W'($urandom);
		for (int i = 0; i < 4; i++) begin
			cfg_bus.valid <= 1'b1;
			cfg_bus.index <= idx[i];
			cfg_bus.data  <= value[i];
			do @(posedge clk); while (!cfg_bus.ready);
			reg_writes++;
		end
		cfg_bus.valid <= 1'b0;
		crit_pm = value[0];
		low_pm  = value[1];
		full_pm = value[2];
	endtask

	task automatic run_random(int count);
		for (int i = 0; i < count; i++)
			send_beat(random_beat());
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Manual sets on both LEDs, then the power LED through every chipset state
	task automatic test_manual_and_power();
		send_beat(make_manual(1'b0, 255, 255));   // both pins
		send_beat(make_manual(1'b0, 0, 1));       // amber only
		send_beat(make_manual(1'b1, 128, 0));     // blue only
		send_beat(make_manual(1'b1, 0, 0));       // off
		send_beat(make_tick(1'b1, 1'b0, CHIP_ON, CHG_OTHER, 1'b0, 0, 0));
		send_beat(make_tick(1'b1, 1'b0, CHIP_TRANS, CHG_OTHER, 1'b0, 0, 0));
		send_beat(make_tick(1'b1, 1'b0, CHIP_OFF, CHG_OTHER, 1'b0, 0, 0));
		// suspend entry restarts the count: amber for four ticks, then dark
		for (int i = 0; i < 5; i++)
			send_beat(make_tick(1'b1, 1'b0, CHIP_SUSPEND, CHG_OTHER, 1'b0, 0, 0));
		send_beat(make_tick(1'b1, 1'b0, CHIP_ON, CHG_OTHER, 1'b0, 0, 0));
		send_beat(make_tick(1'b1, 1'b0, CHIP_SUSPEND, CHG_OTHER, 1'b0, 0, 0));
	endtask

	// Battery LED through every charge state at the reset thresholds
	task automatic test_battery_states();
		send_beat(make_tick(1'b0, 1'b1, CHIP_ON, CHG_CHARGE, 1'b0, 65535, 0));  // zero full
		send_beat(make_tick(1'b0, 1'b1, CHIP_ON, CHG_CHARGE, 1'b0, 65535, 1));  // way over 1000
		send_beat(make_tick(1'b0, 1'b1, CHIP_ON, CHG_NEAR_FULL, 1'b0, 500, 1000));
		send_beat(make_tick(1'b0, 1'b1, CHIP_ON, CHG_DISCHARGE, 1'b0, 71, 1000));   // at critical
		send_beat(make_tick(1'b0, 1'b1, CHIP_ON, CHG_DISCHARGE, 1'b0, 137, 1000));  // at low
		send_beat(make_tick(1'b0, 1'b1, CHIP_ON, CHG_DISCHARGE, 1'b0, 138, 1000));  // above low
		send_beat(make_tick(1'b0, 1'b1, CHIP_OFF, CHG_DISCHARGE, 1'b0, 0, 1000));   // chipset off
		send_beat(make_tick(1'b0, 1'b1, CHIP_ON, CHG_ERROR, 1'b0, 0, 0));
		send_beat(make_tick(1'b0, 1'b1, CHIP_ON, CHG_IDLE, 1'b1, 0, 0));
		send_beat(make_tick(1'b0, 1'b1, CHIP_ON, CHG_IDLE, 1'b0, 0, 0));
		send_beat(make_tick(1'b1, 1'b1, CHIP_SUSPEND, CHG_OTHER, 1'b1, 65535, 65535));
	endtask

	// Thresholds at both ends of their range
	task automatic test_threshold_extremes();
		apply_thresholds(0, 0, 0);
		for (int i = 0; i < 3; i++)
			send_beat(make_tick(1'b0, 1'b1, CHIP_ON, CHG_DISCHARGE, 1'b0, 0, 1000));
		send_beat(make_tick(1'b0, 1'b1, CHIP_ON, CHG_DISCHARGE, 1'b0, 1, 1000));
		send_beat(make_tick(1'b0, 1'b1, CHIP_ON, CHG_CHARGE, 1'b0, 0, 1000));
		run_random(30);

		apply_thresholds(1000, 1000, 1000);
		send_beat(make_tick(1'b0, 1'b1, CHIP_ON, CHG_DISCHARGE, 1'b0, 1000, 1000));
		send_beat(make_tick(1'b0, 1'b1, CHIP_TRANS, CHG_DISCHARGE, 1'b0, 1001, 1000));
		send_beat(make_tick(1'b0, 1'b1, CHIP_ON, CHG_CHARGE, 1'b0, 999, 1000));
		send_beat(make_tick(1'b0, 1'b1, CHIP_ON, CHG_CHARGE, 1'b0, 1000, 1000));
		run_random(30);
	endtask

	// Random traffic under four idle mixes, fresh thresholds for each
	task automatic test_random_traffic();
		int src_mix [4] = '{0, 62, 0, 7};
		int snk_mix [4] = '{0, 0, 62, 7};
		int a;
		int c;
		for (int ph = 0; ph < 4; ph++) begin
			a = $urandom_range(1000);
			c = $urandom_range(1000);
			// usually critical below low, sometimes the other way round
			if ($urandom_range(3) != 0 && a > c)
				apply_thresholds(c, a, $urandom_range(1000));
			else
				apply_thresholds(a, c, $urandom_range(1000));
			src_idle_pct = src_mix[ph];
			snk_stall_pct <= snk_mix[ph];
			run_random(300);
		end
	endtask

	// Receiver holds off for a long stretch while beats keep coming
	task automatic test_backpressure();
		drain();
		src_idle_pct = 0;
		snk_stall_pct <= 0;
		hold_seq <= hold_seq + 1;
		run_random(25);
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls, plus a long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		int hold_left;
		hold_left = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_seq) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: oldest expectation against each accepted beat
	// ------------------------------------------------------------------
	function automatic void note_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH @%0t: %s", $time, what);
	endfunction

	function automatic void check_pin(string pin, logic want, logic got);
		if (got !== want)
			note_mismatch($sformatf("%s expected %0b got %0b", pin, want, got));
	endfunction

	logic [LEDS_W-1:0] want_leds;

	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			results_seen++;
			if (expected_leds.size() == 0) begin
				note_mismatch("result beat with nothing expected");
			end else begin
				want_leds = expected_leds.pop_front();
				check_pin("power_blue", want_leds[0], result_bus.power_blue);
				check_pin("power_amber", want_leds[1], result_bus.power_amber);
				check_pin("battery_blue", want_leds[2], result_bus.battery_blue);
				check_pin("battery_amber", want_leds[3], result_bus.battery_amber);
			end
		end
	end

	// Watchdog: too long with no beat on any channel means a hang
	always @(posedge clk) begin
		if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
		    (cfg_bus.valid && cfg_bus.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("charge_status_led_controller verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		item_bus.valid              <= 1'b0;
		item_bus.op                 <= OP_TICK;
		item_bus.led_select         <= 1'b0;
		item_bus.blue_level         <= '0;
		item_bus.yellow_level       <= '0;
		item_bus.power_auto         <= 1'b0;
		item_bus.battery_auto       <= 1'b0;
		item_bus.chipset_state      <= CHIP_OFF;
		item_bus.chg_state          <= CHG_CHARGE;
		item_bus.force_idle         <= 1'b0;
		item_bus.remain_cap         <= '0;
		item_bus.full_capacity      <= '0;
		cfg_bus.valid               <= 1'b0;
		cfg_bus.index               <= CFG_CRITICAL;
		cfg_bus.data                <= '0;

		// predictor matches the block's reset state
		crit_pm    = CRITICAL_RST;
		low_pm     = LOW_RST;
		full_pm    = FULL_RST;
		pwr_ticks  = '0;
		in_suspend = 1'b0;
		batt_ticks = '0;
		leds       = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_manual_and_power();
		test_battery_states();
		test_threshold_extremes();
		test_random_traffic();
		test_backpressure();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d ticks and %0d manual sets, %0d results checked, %0d config writes,",
		         ticks_sent, manuals_sent, results_seen, reg_writes);
		$display("over threshold extremes, four idle mixes and one long receiver hold-off.");
		if (mismatches == 0 && expected_leds.size() == 0) begin
			$display("charge_status_led_controller verification clean");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_leds.size());
			$display("charge_status_led_controller verification failed");
		end
		$finish;
	end

endmodule

[files.f]
rtl/csl_pkg.sv
rtl/csl_if.sv
rtl/csl_permille_div.sv
rtl/csl_led_update.sv
rtl/charge_status_led_controller.sv
test/charge_status_led_controller_test.sv
